// ----- design/fractal_value_noise_defines.svh -----
// ----------------------------------------------------------------------------
// Fractal value noise: assertion macros
// Shared concurrent-assertion shorthands, clocked on clk_i and held off in reset.
// ----------------------------------------------------------------------------
`ifndef FRACTAL_VALUE_NOISE_DEFINES_SVH
`define FRACTAL_VALUE_NOISE_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define FVN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent
`define FVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/fvn_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractal value noise package
// Fixed-point formats, widths, hash constants and config limits.
// ----------------------------------------------------------------------------
package fvn_pkg;

  // Coordinate and result format
  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned OUT_W           = FRAC_BITS + 2;
  localparam int unsigned MAX_OCTAVES_DEF = 8;

  // Frequency: Q16 start, up to 4x per octave over at most 16 octaves
  localparam int unsigned FREQ_W    = 47;
  localparam int unsigned FREQ_LO_W = 24;
  localparam logic [FREQ_W-1:0] FREQ_INIT = FREQ_W'(64'd1 << (32 - FRAC_BITS));

  // Amplitude: unsigned Q32, starts at 1.0
  localparam int unsigned AMP_W = 33;
  localparam logic [AMP_W-1:0] AMP_INIT = AMP_W'(64'd1 << 32);

  // Octave term (Q38), lane sum, total amplitude, divider
  localparam int unsigned TERM_W    = 40;
  localparam int unsigned SUM_W     = TERM_W + 4;
  localparam int unsigned TOTAL_W   = AMP_W + 4;
  localparam int unsigned NUM_SHIFT = FRAC_BITS - 6;
  localparam int unsigned REM_W     = SUM_W + NUM_SHIFT;
  localparam int unsigned QUO_W     = FRAC_BITS + 1;

  // Lane pipeline depth, coordinate register to octave term register
  localparam int unsigned LANE_LAT = 10;

  // Lattice hash constants
  localparam logic [31:0] HASH_X    = 32'd73856093;
  localparam logic [31:0] HASH_Z    = 32'd19349663;
  localparam logic [31:0] HASH_S    = 32'd83492791;
  localparam logic [31:0] MIX_MUL   = 32'd15731;
  localparam logic [31:0] MIX_ADD   = 32'd789221;
  localparam logic [31:0] MIX_OFF   = 32'd1376312589;
  localparam logic [31:0] SEED_STEP = 32'd1013;
  localparam logic [31:0] CORNER_ONE = 32'h4000_0000;

  // Smoothstep constant 3.0 in Q16
  localparam logic [17:0] SMOOTH_K = 18'd196608;

  // Config limits
  localparam logic [15:0] PERS_MIN = 16'd6554;
  localparam logic [15:0] PERS_MAX = 16'd62259;
  localparam logic [15:0] LAC_MIN  = 16'd9011;
  localparam logic [15:0] LAC_MAX  = 16'd32768;

endpackage

// ----- design/fvn_octave_lane.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractal value noise: octave lane
// One octave of value noise, pipelined over ten stages, one point per cycle.
// ----------------------------------------------------------------------------
module fvn_octave_lane (
  input  logic                              clk_i,
  input  logic signed [31:0]                coord_x_i,
  input  logic signed [31:0]                coord_z_i,
  input  logic [fvn_pkg::FREQ_W-1:0]        freq_i,
  input  logic [fvn_pkg::AMP_W-1:0]         amp_i,
  input  logic [31:0]                       seed_mix_i,
  output logic signed [fvn_pkg::TERM_W-1:0] term_o
);

  localparam int unsigned LO_W = fvn_pkg::FREQ_LO_W;
  localparam int unsigned HI_W = fvn_pkg::FREQ_W - fvn_pkg::FREQ_LO_W;

  // a*(1-w) + b*w in Q46, floored back to Q30
  function automatic logic signed [31:0] lerp_q30(input logic signed [31:0] a,
                                                  input logic signed [31:0] b,
                                                  input logic [16:0] w);
    logic [16:0]        wi;
    logic signed [49:0] acc;
    wi  = 17'(17'd65536 - w);
    acc = 50'(a) * 50'($signed({1'b0, wi})) + 50'(b) * 50'($signed({1'b0, w}));
    return 32'(acc >>> 16);
  endfunction

  // Stage 1: coordinate times frequency, split in two partial products
  logic signed [LO_W+32:0] pxl_q, pzl_q;
  logic signed [HI_W+32:0] pxh_q, pzh_q;

  always_ff @(posedge clk_i) begin
    pxl_q <= coord_x_i * $signed({1'b0, freq_i[LO_W-1:0]});
    pzl_q <= coord_z_i * $signed({1'b0, freq_i[LO_W-1:0]});
    pxh_q <= coord_x_i * $signed({1'b0, freq_i[fvn_pkg::FREQ_W-1:LO_W]});
    pzh_q <= coord_z_i * $signed({1'b0, freq_i[fvn_pkg::FREQ_W-1:LO_W]});
  end

  // Stage 2: Q32 position mod 2^64, lattice index and fraction
  logic [63:0] px_s, pz_s;
  logic [31:0] ix_q, iz_q;
  logic [15:0] fx_q, fz_q;

  assign px_s = 64'(pxl_q) + (64'(pxh_q) << LO_W);
  assign pz_s = 64'(pzl_q) + (64'(pzh_q) << LO_W);

  always_ff @(posedge clk_i) begin
    ix_q <= px_s[63:32];
    iz_q <= pz_s[63:32];
    fx_q <= px_s[31:16];
    fz_q <= pz_s[31:16];
  end

  // Stage 3: index hash products, fraction squared, 3 - 2f
  logic [31:0] ixa_q, izb_q, ffx_q, ffz_q;
  logic [17:0] gx_q, gz_q;

  always_ff @(posedge clk_i) begin
    ixa_q <= ix_q * fvn_pkg::HASH_X;
    izb_q <= iz_q * fvn_pkg::HASH_Z;
    ffx_q <= fx_q * fx_q;
    ffz_q <= fz_q * fz_q;
    gx_q  <= fvn_pkg::SMOOTH_K - {1'b0, fx_q, 1'b0};
    gz_q  <= fvn_pkg::SMOOTH_K - {1'b0, fz_q, 1'b0};
  end

  // Stage 4: corner seeds (00, 10, 01, 11), bit mix, smoothstep weights
  logic [31:0]      xa1_s, zb1_s;
  logic [3:0][31:0] nb_s;
  logic [49:0]      upr_s, vpr_s;
  logic [3:0][31:0] n_q;
  logic [16:0]      u_q, v_q;

  assign xa1_s = ixa_q + fvn_pkg::HASH_X;
  assign zb1_s = izb_q + fvn_pkg::HASH_Z;
  assign nb_s[0] = ixa_q ^ izb_q ^ seed_mix_i;
  assign nb_s[1] = xa1_s ^ izb_q ^ seed_mix_i;
  assign nb_s[2] = ixa_q ^ zb1_s ^ seed_mix_i;
  assign nb_s[3] = xa1_s ^ zb1_s ^ seed_mix_i;
  assign upr_s = 50'(ffx_q) * 50'(gx_q);
  assign vpr_s = 50'(ffz_q) * 50'(gz_q);

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      n_q[c] <= {nb_s[c][18:0], 13'd0} ^ nb_s[c];
    end
    u_q <= 17'(upr_s >> 32);
    v_q <= 17'(vpr_s >> 32);
  end

  // Stage 5: n squared
  logic [3:0][31:0] sq_q, n5_q;
  logic [16:0]      u5_q, v5_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      sq_q[c] <= n_q[c] * n_q[c];
    end
    n5_q <= n_q;
    u5_q <= u_q;
    v5_q <= v_q;
  end

  // Stage 6: n*n*15731 + 789221
  logic [3:0][31:0] m_q, n6_q;
  logic [16:0]      u6_q, v6_q;

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      m_q[c] <= sq_q[c] * fvn_pkg::MIX_MUL + fvn_pkg::MIX_ADD;
    end
    n6_q <= n5_q;
    u6_q <= u5_q;
    v6_q <= v5_q;
  end

  // Stage 7: final hash, mapped to a Q30 corner value in (-1, 1]
  logic [3:0][31:0] t_s;
  logic [3:0][31:0] cv_q;
  logic [16:0]      u7_q, v7_q;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      t_s[c] = n6_q[c] * m_q[c] + fvn_pkg::MIX_OFF;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) begin
      cv_q[c] <= fvn_pkg::CORNER_ONE - {1'b0, t_s[c][30:0]};
    end
    u7_q <= u6_q;
    v7_q <= v6_q;
  end

  // Stage 8: blend along x
  logic signed [31:0] r0_q, r1_q;
  logic [16:0]        v8_q;

  always_ff @(posedge clk_i) begin
    r0_q <= lerp_q30($signed(cv_q[0]), $signed(cv_q[1]), u7_q);
    r1_q <= lerp_q30($signed(cv_q[2]), $signed(cv_q[3]), u7_q);
    v8_q <= v7_q;
  end

  // Stage 9: blend along z
  logic signed [31:0] val_q;

  always_ff @(posedge clk_i) begin
    val_q <= lerp_q30(r0_q, r1_q, v8_q);
  end

  // Stage 10: scale by amplitude, floor to Q38
  logic signed [65:0] tp_s;

  assign tp_s = 66'(val_q) * 66'($signed({1'b0, amp_i}));

  always_ff @(posedge clk_i) begin
    term_o <= fvn_pkg::TERM_W'(tp_s >>> 24);
  end

endmodule

// ----- design/fractal_value_noise.sv -----
`timescale 1ns / 1ps
// Throughput: one coordinate pair per cycle while busy is low; every
// octave has its own lane, and the normalizing divide is a 17-stage
// one-bit-per-stage pipeline. Reset and every register write rebuild the
// per-octave tables: busy stays high through the load state and the run
// state walking all MAX_OCTAVES entries. Results are strobed and never held.
// ----------------------------------------------------------------------------
// Fractal value noise
// Sums up to MAX_OCTAVES octaves of lattice value noise at a Q16.16 point
// and returns the amplitude-weighted mean in signed Q1.16.
// ----------------------------------------------------------------------------
`include "fractal_value_noise_defines.svh"

module fractal_value_noise #(
  parameter int unsigned MAX_OCTAVES = fvn_pkg::MAX_OCTAVES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // command side
  input  logic                             start,
  output logic                             busy,
  input  logic signed [31:0]               coord_x_i,
  input  logic signed [31:0]               coord_z_i,
  output logic                             result_valid_o,
  output logic signed [fvn_pkg::OUT_W-1:0] noise_value_o,
  // register port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [3:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  localparam int unsigned IW       = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;
  localparam int unsigned OW       = $clog2(MAX_OCTAVES + 1);
  localparam int unsigned GRP_SIZE = 4;
  localparam int unsigned NGRP     = (MAX_OCTAVES + GRP_SIZE - 1) / GRP_SIZE;
  localparam int unsigned QW       = fvn_pkg::QUO_W;
  localparam int unsigned RW       = fvn_pkg::REM_W;
  localparam int unsigned DIV_END  = fvn_pkg::LANE_LAT + 3 + QW;
  localparam int unsigned LAT      = DIV_END + 2;

  localparam logic [1:0] REG_SEED = 2'd0;
  localparam logic [1:0] REG_OCT  = 2'd1;
  localparam logic [1:0] REG_PERS = 2'd2;
  localparam logic [1:0] REG_LAC  = 2'd3;

  localparam logic [1:0] SEQ_IDLE = 2'd0;
  localparam logic [1:0] SEQ_LOAD = 2'd1;
  localparam logic [1:0] SEQ_RUN  = 2'd2;

  // --------------------------------------------------------------------------
  // Register port
  // --------------------------------------------------------------------------
  logic        cfg_wr;
  logic [31:0] seed_q;
  logic [3:0]  oct_q;
  logic [15:0] pers_q, lac_q;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= '0;
      oct_q  <= 4'd4;
      pers_q <= 16'd32768;
      lac_q  <= 16'd16384;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_SEED: seed_q <= pwdata;
        REG_OCT:  oct_q  <= pwdata[3:0];
        REG_PERS: pers_q <= pwdata[15:0];
        REG_LAC:  lac_q  <= pwdata[15:0];
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (paddr[3:2])
      REG_SEED: prdata = seed_q;
      REG_OCT:  prdata = {28'd0, oct_q};
      REG_PERS: prdata = {16'd0, pers_q};
      REG_LAC:  prdata = {16'd0, lac_q};
    endcase
  end

  // Clamped settings
  logic [OW-1:0] oct_c;
  logic [15:0]   pers_c, lac_c;

  always_comb begin
    priority if (oct_q == 4'd0) oct_c = OW'(1);
    else if (32'(oct_q) > MAX_OCTAVES) oct_c = OW'(MAX_OCTAVES);
    else oct_c = OW'(oct_q);
    priority if (pers_q < fvn_pkg::PERS_MIN) pers_c = fvn_pkg::PERS_MIN;
    else if (pers_q > fvn_pkg::PERS_MAX) pers_c = fvn_pkg::PERS_MAX;
    else pers_c = pers_q;
    priority if (lac_q < fvn_pkg::LAC_MIN) lac_c = fvn_pkg::LAC_MIN;
    else if (lac_q > fvn_pkg::LAC_MAX) lac_c = fvn_pkg::LAC_MAX;
    else lac_c = lac_q;
  end

  // --------------------------------------------------------------------------
  // Octave table sequencer: frequency, amplitude, seed mix, total amplitude
  // --------------------------------------------------------------------------
  logic [1:0]                  state_q, state_d;
  logic [IW-1:0]               k_q;
  logic [fvn_pkg::FREQ_W-1:0]  freq_cur_q;
  logic [fvn_pkg::AMP_W-1:0]   amp_cur_q;
  logic [31:0]                 seed_cur_q;
  logic [fvn_pkg::TOTAL_W-1:0] total_q;
  logic                        k_last;
  logic [fvn_pkg::FREQ_W+15:0] fprod_s;
  logic [fvn_pkg::AMP_W+15:0]  aprod_s;

  logic [fvn_pkg::FREQ_W-1:0] freq_tab_q [MAX_OCTAVES];
  logic [fvn_pkg::AMP_W-1:0]  amp_tab_q  [MAX_OCTAVES];
  logic [31:0]                mix_tab_q  [MAX_OCTAVES];

  assign k_last  = (k_q == IW'(MAX_OCTAVES - 1));
  assign fprod_s = freq_cur_q * lac_c;
  assign aprod_s = amp_cur_q * pers_c;
  assign busy    = (state_q != SEQ_IDLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      SEQ_IDLE: state_d = SEQ_IDLE;
      SEQ_LOAD: state_d = SEQ_RUN;
      SEQ_RUN:  state_d = k_last ? SEQ_IDLE : SEQ_RUN;
      default:  state_d = SEQ_IDLE;
    endcase
    if (cfg_wr) state_d = SEQ_LOAD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= SEQ_LOAD;
      k_q        <= '0;
      freq_cur_q <= fvn_pkg::FREQ_INIT;
      amp_cur_q  <= fvn_pkg::AMP_INIT;
      seed_cur_q <= '0;
      total_q    <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == SEQ_LOAD) begin
        k_q        <= '0;
        freq_cur_q <= fvn_pkg::FREQ_INIT;
        amp_cur_q  <= fvn_pkg::AMP_INIT;
        seed_cur_q <= seed_q;
        total_q    <= '0;
      end else if (state_q == SEQ_RUN) begin
        k_q        <= k_last ? k_q : k_q + IW'(1);
        freq_cur_q <= fvn_pkg::FREQ_W'(fprod_s >> 13);
        amp_cur_q  <= fvn_pkg::AMP_W'(aprod_s >> 16);
        seed_cur_q <= seed_cur_q + fvn_pkg::SEED_STEP;
        if (32'(k_q) < 32'(oct_c)) begin
          total_q <= total_q + fvn_pkg::TOTAL_W'(amp_cur_q);
        end
      end
    end
  end

  // Table entries are written as the sequencer walks the octaves
  always_ff @(posedge clk_i) begin
    if (state_q == SEQ_RUN) begin
      freq_tab_q[k_q] <= freq_cur_q;
      amp_tab_q[k_q]  <= amp_cur_q;
      mix_tab_q[k_q]  <= seed_cur_q * fvn_pkg::HASH_S;
    end
  end

  // --------------------------------------------------------------------------
  // Input register and valid chain
  // --------------------------------------------------------------------------
  logic               in_xfer;
  logic signed [31:0] cx_q, cz_q;
  logic [LAT-1:0]     vld_q;

  assign in_xfer = start && !busy;

  always_ff @(posedge clk_i) begin
    cx_q <= coord_x_i;
    cz_q <= coord_z_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[LAT-2:0], in_xfer};
    end
  end

  // --------------------------------------------------------------------------
  // Octave lanes
  // --------------------------------------------------------------------------
  logic signed [fvn_pkg::TERM_W-1:0] term_s [MAX_OCTAVES];

  for (genvar gi = 0; gi < MAX_OCTAVES; gi++) begin : g_lane
    fvn_octave_lane u_lane (
      .clk_i      (clk_i),
      .coord_x_i  (cx_q),
      .coord_z_i  (cz_q),
      .freq_i     (freq_tab_q[gi]),
      .amp_i      (amp_tab_q[gi]),
      .seed_mix_i (mix_tab_q[gi]),
      .term_o     (term_s[gi])
    );
  end

  // --------------------------------------------------------------------------
  // Octave sum: groups of four, then the final add
  // --------------------------------------------------------------------------
  logic signed [fvn_pkg::SUM_W-1:0] grp_d [NGRP];
  logic signed [fvn_pkg::SUM_W-1:0] grp_q [NGRP];
  logic signed [fvn_pkg::SUM_W-1:0] sum_d, sum_q;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_d[g] = '0;
    end
    for (int i = 0; i < MAX_OCTAVES; i++) begin
      if (i < 32'(oct_c)) begin
        grp_d[i / GRP_SIZE] = grp_d[i / GRP_SIZE] + fvn_pkg::SUM_W'(term_s[i]);
      end
    end
    sum_d = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum_d = sum_d + grp_q[g];
    end
  end

  always_ff @(posedge clk_i) begin
    grp_q <= grp_d;
    sum_q <= sum_d;
  end

  // --------------------------------------------------------------------------
  // Normalize: |sum * 2^10| / total, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic signed [RW-1:0] num_s;
  logic                 neg_s;
  logic [RW-1:0]        rem_d [QW+1];
  logic [QW-1:0]        quo_d [QW+1];
  logic [RW-1:0]        rem_q [QW+1];
  logic [QW-1:0]        quo_q [QW+1];
  logic                 neg_q [QW+1];
  logic [RW-1:0]        dsh_s [QW];

  assign num_s = RW'(sum_q) <<< fvn_pkg::NUM_SHIFT;
  assign neg_s = num_s[RW-1];

  always_comb begin
    rem_d[0] = neg_s ? RW'(-num_s) : RW'(num_s);
    quo_d[0] = '0;
    for (int j = 0; j < QW; j++) begin
      dsh_s[j]     = RW'(total_q) << (QW - 1 - j);
      rem_d[j + 1] = rem_q[j];
      quo_d[j + 1] = quo_q[j];
      if (rem_q[j] >= dsh_s[j]) begin
        rem_d[j + 1]             = rem_q[j] - dsh_s[j];
        quo_d[j + 1][QW - 1 - j] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    neg_q[0] <= neg_s;
    for (int j = 0; j < QW; j++) begin
      neg_q[j + 1] <= neg_q[j];
    end
  end

  // --------------------------------------------------------------------------
  // Sign, clamp to +-1.0, result register
  // --------------------------------------------------------------------------
  localparam logic signed [fvn_pkg::OUT_W-1:0] ONE_Q =
    fvn_pkg::OUT_W'(64'd1 << fvn_pkg::FRAC_BITS);

  logic signed [fvn_pkg::OUT_W-1:0] mag_s, res_s, clip_s;

  always_comb begin
    mag_s = $signed({1'b0, quo_q[QW]});
    res_s = neg_q[QW] ? -mag_s : mag_s;
    priority if (res_s > ONE_Q) clip_s = ONE_Q;
    else if (res_s < -ONE_Q) clip_s = -ONE_Q;
    else clip_s = res_s;
  end

  always_ff @(posedge clk_i) begin
    noise_value_o <= clip_s;
  end

  assign result_valid_o = vld_q[LAT-1];

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `FVN_ASSERT_NOW(a_result_has_source, result_valid_o, $past(in_xfer, LAT), "stray result")
  `FVN_ASSERT_NEXT(a_write_rebuilds, cfg_wr, busy, "write did not start a table rebuild")
  `FVN_ASSERT_NOW(a_quotient_fits, vld_q[DIV_END], rem_q[QW] < RW'(total_q), "bad remainder")

endmodule

// ----- bench/tb_fractal_value_noise.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fractal value noise testbench
// Drives coordinate pairs through the command port under several register
// settings and sender gap patterns. Results are checked against a typed
// value or an in-bench fixed-point model of the normalized octave sum.
// ----------------------------------------------------------------------------
module tb_fractal_value_noise;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_WAIT  = 40;

  // Register addresses
  localparam logic [3:0] ADDR_SEED = 4'd0;
  localparam logic [3:0] ADDR_OCT  = 4'd4;
  localparam logic [3:0] ADDR_PERS = 4'd8;
  localparam logic [3:0] ADDR_LAC  = 4'd12;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic               result_valid_o;
  logic signed [fvn_pkg::OUT_W-1:0] noise_value_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Shadow copy of the registers
  logic [31:0] seed_r = 32'd0;
  logic [3:0]  oct_r  = 4'd4;
  logic [15:0] pers_r = 16'd32768;
  logic [15:0] lac_r  = 16'd16384;

  logic signed [fvn_pkg::OUT_W-1:0] noise_q[$];
  int unsigned                      err_cnt = 0;
  int unsigned                      cyc_cnt = 0;

  fractal_value_noise u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .coord_x_i(coord_x_i), .coord_z_i(coord_z_i),
    .result_valid_o(result_valid_o), .noise_value_o(noise_value_o),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Lattice corner value, Q30 in (-1,1]
  function automatic longint lattice_corner(logic [31:0] ix, logic [31:0] iz,
                                            logic [31:0] s);
    logic [31:0] n;
    logic [31:0] t;
    n = (ix * fvn_pkg::HASH_X) ^ (iz * fvn_pkg::HASH_Z) ^ (s * fvn_pkg::HASH_S);
    n = (n << 13) ^ n;
    t = n * (n * n * fvn_pkg::MIX_MUL + fvn_pkg::MIX_ADD) + fvn_pkg::MIX_OFF;
    return longint'(1 << 30) - longint'({33'd0, t[30:0]});
  endfunction

  function automatic longint blend_q30(longint a, longint b, longint w);
    return (a * (65536 - w) + b * w) >>> 16;
  endfunction

  function automatic longint smooth_w(logic [63:0] f);
    logic [63:0] p;
    p = f * f * (64'd196608 - 64'd2 * f);
    return longint'(p >> 32);
  endfunction

  // Expected noise for one coordinate pair under the shadow registers
  function automatic logic signed [fvn_pkg::OUT_W-1:0] noise_predict(
    logic signed [31:0] cx, logic signed [31:0] cz);
    int unsigned oct;
    logic [63:0] pers, lac, freq, amp, total, nf, px, pz;
    longint      sum, r, u, v, r0, r1, val;
    logic [31:0] s, ix, iz;
    oct  = (oct_r == 0) ? 1 :
           ((oct_r > fvn_pkg::MAX_OCTAVES_DEF) ? fvn_pkg::MAX_OCTAVES_DEF : oct_r);
    pers = (pers_r < fvn_pkg::PERS_MIN) ? fvn_pkg::PERS_MIN :
           ((pers_r > fvn_pkg::PERS_MAX) ? fvn_pkg::PERS_MAX : pers_r);
    lac  = (lac_r < fvn_pkg::LAC_MIN) ? fvn_pkg::LAC_MIN :
           ((lac_r > fvn_pkg::LAC_MAX) ? fvn_pkg::LAC_MAX : lac_r);
    freq = 64'd1 << (32 - fvn_pkg::FRAC_BITS);
    amp  = 64'd1 << 32;
    total = 0;
    sum   = 0;
    for (int i = 0; i < oct; i++) begin
      s  = seed_r + i * fvn_pkg::SEED_STEP;
      px = {{32{cx[31]}}, cx} * freq;
      pz = {{32{cz[31]}}, cz} * freq;
      ix = px[63:32];
      iz = pz[63:32];
      u  = smooth_w({48'd0, px[31:16]});
      v  = smooth_w({48'd0, pz[31:16]});
      r0 = blend_q30(lattice_corner(ix, iz, s), lattice_corner(ix + 1, iz, s), u);
      r1 = blend_q30(lattice_corner(ix, iz + 1, s),
                     lattice_corner(ix + 1, iz + 1, s), u);
      val = blend_q30(r0, r1, v);
      sum += (val * longint'(amp)) >>> 24;
      total += amp;
      amp = (amp * pers) >> 16;
      nf = (freq >> 13) * lac + (((freq & 64'h1fff) * lac) >> 13);
      freq = (nf > (64'd1 << 56)) ? (64'd1 << 56) : nf;
    end
    r = (sum * (longint'(1) << (fvn_pkg::FRAC_BITS - 6))) / longint'(total);
    if (r > (longint'(1) << fvn_pkg::FRAC_BITS)) r = longint'(1) << fvn_pkg::FRAC_BITS;
    if (r < -(longint'(1) << fvn_pkg::FRAC_BITS)) r = -(longint'(1) << fvn_pkg::FRAC_BITS);
    return r[fvn_pkg::OUT_W-1:0];
  endfunction

  // Result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (noise_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10) $display("unexpected result %0d", noise_value_o);
      end else begin
        logic signed [fvn_pkg::OUT_W-1:0] want;
        want = noise_q.pop_front();
        if (want !== noise_value_o) begin
          err_cnt++;
          if (err_cnt <= 10)
            $display("noise mismatch: expected %0d, got %0d", want, noise_value_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cyc_cnt++;
    if (cyc_cnt > CYCLE_LIMIT) begin
      $display("[fractal_value_noise] ERROR");
      $finish;
    end
  end

  // One register write: setup then access
  task automatic reg_write(logic [3:0] addr, logic [31:0] data);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // Drain outstanding results, then load all four registers
  task automatic load_regs(logic [31:0] sd, logic [3:0] oc, logic [15:0] pe,
                           logic [15:0] la);
    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    reg_write(ADDR_SEED, sd);
    reg_write(ADDR_OCT, {28'd0, oc});
    reg_write(ADDR_PERS, {16'd0, pe});
    reg_write(ADDR_LAC, {16'd0, la});
    seed_r = sd; oct_r = oc; pers_r = pe; lac_r = la;
  endtask

  // Hold one transfer on the command port until accepted
  task automatic send_pair(logic signed [31:0] x, logic signed [31:0] z,
                           int unsigned idle_pct, logic check_typed,
                           logic signed [fvn_pkg::OUT_W-1:0] typed_val);
    logic signed [fvn_pkg::OUT_W-1:0] exp_val;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    start <= 1'b1; coord_x_i <= x; coord_z_i <= z;
    do @(posedge clk_i); while (busy);
    exp_val = check_typed ? typed_val : noise_predict(x, z);
    noise_q = {noise_q, exp_val};
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(0, 32'h000f_ffff) - 32'h0008_0000;
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
      default: return $urandom_range(0, 1) ? 32'h7fff_ffff - $urandom_range(3)
                                           : 32'h8000_0000 + $urandom_range(3);
    endcase
  endfunction

  typedef struct {
    logic signed [31:0] x;
    logic signed [31:0] z;
  } coord_row_t;

  coord_row_t dir_rows[] = '{
    '{32'sh0000_0000, 32'sh0000_0000}, '{32'sh7fff_ffff, 32'sh7fff_ffff},
    '{32'sh8000_0000, 32'sh8000_0000}, '{32'sh7fff_ffff, 32'sh8000_0000},
    '{32'sh0000_8000, 32'sh0000_8000}, '{32'sh0000_ffff, 32'sh0001_0000},
    '{32'shffff_ffff, 32'shffff_0000}, '{32'sh0001_0000, 32'shffff_ffff},
    '{32'sh5555_5555, 32'shaaaa_aaaa}, '{32'sh0000_4000, 32'sh0000_c000},
    '{32'shfffe_8000, 32'sh0003_2000}, '{32'sh1234_5678, 32'shedcb_a987}
  };

  typedef struct {
    logic [31:0] sd;
    logic [3:0]  oc;
    logic [15:0] pe;
    logic [15:0] la;
  } reg_set_t;

  reg_set_t reg_sets[] = '{
    '{32'h0000_0000, 4'd4, 16'd32768, 16'd16384},
    '{32'h7fff_ffff, 4'd8, 16'd62259, 16'd32768},
    '{32'h8000_0000, 4'd1, 16'd6554, 16'd9011},
    '{32'hffff_ffff, 4'd0, 16'd0, 16'd0},
    '{32'h1357_9bdf, 4'd15, 16'd65535, 16'd65535},
    '{32'h0000_03f5, 4'd8, 16'd6554, 16'd32768},
    '{32'hdead_0001, 4'd3, 16'd45000, 16'd20000}
  };

  int unsigned idle_pcts[] = '{0, 70, 20, 0, 70, 20, 70};

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: reset values, then one octave at seed 0: origin, then rows
    foreach (dir_rows[i]) send_pair(dir_rows[i].x, dir_rows[i].z, 0, 1'b0, '0);
    start <= 1'b0;
    load_regs(32'd0, 4'd1, 16'd32768, 16'd16384);
    send_pair(32'sd0, 32'sd0, 0, 1'b1, -18'sd18467);
    foreach (dir_rows[i]) send_pair(dir_rows[i].x, dir_rows[i].z, 0, 1'b0, '0);

    // Random phases, one per register setting
    foreach (reg_sets[p]) begin
      start <= 1'b0;
      load_regs(reg_sets[p].sd, reg_sets[p].oc, reg_sets[p].pe, reg_sets[p].la);
      repeat (130) send_pair(rand_coord(), rand_coord(), idle_pcts[p], 1'b0, '0);
    end
    start <= 1'b0;

    while (noise_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("[fractal_value_noise] OK");
    end else begin
      $display("[fractal_value_noise] ERROR");
    end
    $finish;
  end

endmodule
